// ===== rtl/core/dutc_pkg.sv =====
// Shared types and constants for the disciplined UTC clock.
// No dependencies; imported by every module of the block.
`default_nettype none

package dutc_pkg;

    // Field widths fixed by the item formats
    localparam int ADJ_W  = 48;
    localparam int TIME_W = 64;
    localparam int CORR_W = 12;
    localparam int CFG_W  = 8;

    // Defaults for the top-level parameters
    localparam int USEC_PER_PERIOD_DEF = 131072;
    localparam int MAX_CORR_X16_DEF    = 1600;

    // An adjustment at or above this magnitude steps the UTC time
    localparam int STEP_THRESHOLD_USEC = 3000;

    // Reset value of the cycles-per-microsecond register
    localparam logic [CFG_W-1:0] CYCLES_PER_USEC_RST = 8'd48;

    // Kind of input item
    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_ADJUST = 1'b1
    } action_t;

    // One input item as held in the input register
    typedef struct packed {
        action_t                  action;
        logic signed [ADJ_W-1:0]  adj;
    } dutc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/dutc_in_stage.sv =====
// Input register of the disciplined UTC clock.
// Uses dutc_pkg for the item type.
`default_nettype none

module dutc_in_stage
    import dutc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // upstream side
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire dutc_item_t up_item,
    // downstream side
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output dutc_item_t      dn_item
);

    logic       valid_reg;
    dutc_item_t item_reg;

    // Take a new item whenever the held one leaves or none is held
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            item_reg <= up_item;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dutc_update.sv =====
// Clock state, its single-pass update and the result register.
// Uses dutc_pkg for widths, constants and the item type.
`default_nettype none

module dutc_update
    import dutc_pkg::*;
#(
    parameter int USEC_PER_PERIOD = USEC_PER_PERIOD_DEF,
    parameter int MAX_CORR_X16    = MAX_CORR_X16_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [CFG_W-1:0]        cycles_per_usec,
    // item from the input register
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire dutc_item_t              in_item,
    // result side
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [TIME_W-1:0]            mono_usec,
    output logic [TIME_W-1:0]            utc_usec,
    output logic                         utc_valid,
    output logic signed [ADJ_W-1:0]      last_adjustment_usec,
    output logic signed [CORR_W-1:0]     rate_correction_x16
);

    localparam int USEC_W = $clog2(USEC_PER_PERIOD);
    localparam logic [USEC_W:0] PERIOD_CMP = (USEC_W+1)'(USEC_PER_PERIOD);
    localparam logic [TIME_W-1:0] PERIOD_T = TIME_W'(USEC_PER_PERIOD);
    localparam logic signed [CORR_W:0] MAX_CORR = (CORR_W+1)'(MAX_CORR_X16);
    localparam logic [ADJ_W-1:0] STEP_THR = ADJ_W'(STEP_THRESHOLD_USEC);

    // State; mono_read and utc_read carry time plus the in-period count
    logic                       out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]           pre_reg, pre_next;
    logic [USEC_W-1:0]          usec_reg, usec_next;
    logic [TIME_W-1:0]          mono_read_reg, mono_read_next;
    logic [TIME_W-1:0]          utc_time_reg, utc_time_next;
    logic [TIME_W-1:0]          utc_read_reg, utc_read_next;
    logic                       utc_set_reg, utc_set_next;
    logic signed [CORR_W-1:0]   corr_reg, corr_next;
    logic signed [ADJ_W-1:0]    prev_reg, prev_next;

    logic                       advance;
    logic [CFG_W-1:0]           lim;
    logic [CFG_W:0]             pre_inc;
    logic                       usec_step;
    logic [USEC_W:0]            usec_inc;
    logic                       wrap;
    logic signed [CORR_W:0]     corr_ext;
    logic signed [CORR_W:0]     corr_div;
    logic [TIME_W-1:0]          utc_wrap;
    logic signed [ADJ_W-1:0]    adj;
    logic signed [ADJ_W:0]      delta;
    logic                       adj_pos;
    logic                       delta_pos;
    logic signed [CORR_W:0]     corr_sum;
    logic signed [CORR_W:0]     corr_clamp;
    logic [ADJ_W-1:0]           mag;
    logic [TIME_W-1:0]          adj64;
    logic                       do_step;
    logic                       floor_one;

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    // Tick path: prescaler, in-period count, period overflow
    always_comb begin
        lim       = (cycles_per_usec == '0) ? CFG_W'(1) : cycles_per_usec;
        pre_inc   = {1'b0, pre_reg} + (CFG_W+1)'(1);
        usec_step = pre_inc >= {1'b0, lim};
        usec_inc  = {1'b0, usec_reg} + (USEC_W+1)'(1);
        wrap      = usec_inc >= PERIOD_CMP;
        corr_ext  = {corr_reg[CORR_W-1], corr_reg};
        // division by sixteen, truncating toward zero
        corr_div  = corr_ext / 13'sd16;
        utc_wrap  = utc_time_reg + PERIOD_T
                  + {{(TIME_W-CORR_W-1){corr_div[CORR_W]}}, corr_div};
    end

    // Adjust path: correction update and UTC step
    always_comb begin
        adj       = in_item.adj;
        delta     = {adj[ADJ_W-1], adj} - {prev_reg[ADJ_W-1], prev_reg};
        adj_pos   = !adj[ADJ_W-1] && (adj != '0);
        delta_pos = !delta[ADJ_W] && (delta != '0);
        corr_sum  = corr_ext + (adj_pos ? 13'sd1 : -13'sd1)
                  + (delta_pos ? 13'sd1 : -13'sd1);
        if (corr_sum > MAX_CORR) begin
            corr_clamp = MAX_CORR;
        end else if (corr_sum < -MAX_CORR) begin
            corr_clamp = -MAX_CORR;
        end else begin
            corr_clamp = corr_sum;
        end
        mag       = adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);
        adj64     = {{(TIME_W-ADJ_W){adj[ADJ_W-1]}}, adj};
        do_step   = (mag >= STEP_THR) || !utc_set_reg;
        floor_one = adj[ADJ_W-1] && ({{(TIME_W-ADJ_W){1'b0}}, mag} > utc_time_reg);
    end

    // Next state for the item moving in
    always_comb begin
        pre_next       = pre_reg;
        usec_next      = usec_reg;
        mono_read_next = mono_read_reg;
        utc_time_next  = utc_time_reg;
        utc_read_next  = utc_read_reg;
        utc_set_next   = utc_set_reg;
        corr_next      = corr_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance) begin
            out_valid_next = 1'b1;
            case (in_item.action)
                ACT_TICK: begin
                    if (usec_step) begin
                        pre_next       = '0;
                        mono_read_next = mono_read_reg + TIME_W'(1);
                        if (wrap) begin
                            usec_next = '0;
                            if (utc_set_reg) begin
                                utc_time_next = utc_wrap;
                            end
                            utc_read_next = utc_set_reg ? utc_wrap : utc_time_reg;
                        end else begin
                            usec_next     = usec_inc[USEC_W-1:0];
                            utc_read_next = utc_read_reg + TIME_W'(1);
                        end
                    end else begin
                        pre_next = pre_inc[CFG_W-1:0];
                    end
                end
                ACT_ADJUST: begin
                    prev_next = adj;
                    corr_next = corr_clamp[CORR_W-1:0];
                    if (do_step) begin
                        if (floor_one) begin
                            utc_time_next = TIME_W'(1);
                            utc_read_next = TIME_W'(1) + TIME_W'(usec_reg);
                        end else begin
                            utc_time_next = utc_time_reg + adj64;
                            utc_read_next = utc_read_reg + adj64;
                        end
                        if (!utc_set_reg) begin
                            utc_set_next = 1'b1;
                            corr_next    = '0;
                        end
                    end
                end
                default: begin
                    pre_next = pre_reg;
                end
            endcase
        end
    end

    // State registers; all but out_valid_reg change only as an item enters the result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pre_reg       <= '0;
            usec_reg      <= '0;
            mono_read_reg <= '0;
            utc_time_reg  <= '0;
            utc_read_reg  <= '0;
            utc_set_reg   <= 1'b0;
            corr_reg      <= '0;
            prev_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            pre_reg       <= pre_next;
            usec_reg      <= usec_next;
            mono_read_reg <= mono_read_next;
            utc_time_reg  <= utc_time_next;
            utc_read_reg  <= utc_read_next;
            utc_set_reg   <= utc_set_next;
            corr_reg      <= corr_next;
            prev_reg      <= prev_next;
        end
    end

    // Results read straight from the state, which holds while stalled
    assign out_valid            = out_valid_reg;
    assign mono_usec            = mono_read_reg;
    assign utc_usec             = utc_set_reg ? utc_read_reg : '0;
    assign utc_valid            = utc_set_reg;
    assign last_adjustment_usec = prev_reg;
    assign rate_correction_x16  = corr_reg;

`ifndef ASSERT_OFF
    a_corr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (corr_ext <= MAX_CORR) && (corr_ext >= -MAX_CORR))
        else $error("rate correction out of range");

    a_unset_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !utc_set_reg |-> (corr_reg == '0) && (utc_time_reg == '0))
        else $error("correction or UTC moved before UTC was set");

    a_set_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        utc_set_reg |=> utc_set_reg)
        else $error("UTC set flag cleared");

    a_usec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, usec_reg} < PERIOD_CMP)
        else $error("in-period count reached the period");

    a_mono_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (mono_read_reg == $past(mono_read_reg))
                 || (mono_read_reg == $past(mono_read_reg) + TIME_W'(1)))
        else $error("monotonic time moved by more than one microsecond");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> (mono_read_reg == $past(mono_read_reg))
                  && (utc_read_reg == $past(utc_read_reg)))
        else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/disciplined_utc_clock_top.sv =====
// Top level of the disciplined UTC clock: stream ports and the config register.
// Depends on dutc_pkg, dutc_in_stage and dutc_update.
`default_nettype none

// Keeps a monotonic and a UTC microsecond clock. Each tick item stands for
// one core clock cycle; an adjust item feeds a measured UTC error into the
// rate correction and steps UTC when the error is large or UTC is unset.
// Every item gives one result with the current readable times. The block
// takes one item per clock cycle while m_tready is high; an accepted item is
// held in the input register and its result is then loaded into the state
// register, which is also the result register, once that register is empty
// or being taken, and m_tvalid then rises. The state update is one pass of
// adds and compares, so while m_tready is high nothing limits the rate
// below one item a cycle. No clearing pass is needed after reset.
// cycles_per_usec may only be written while idle.

module disciplined_utc_clock_top
    import dutc_pkg::*;
#(
    parameter int USEC_PER_PERIOD = USEC_PER_PERIOD_DEF,
    parameter int MAX_CORR_X16    = MAX_CORR_X16_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: cycles_per_usec
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [47:0]        s_tdata,  // [47:0] adjustment_usec
    input  wire logic [0:0]         s_tuser,  // [0] action
    // result items
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [63:0] mono_usec, [127:64] utc_usec, [128] utc_valid,
    // [176:129] last_adjustment_usec, [188:177] rate_correction_x16, [191:189] zero
    output logic [191:0]            m_tdata
);

    logic [CFG_W-1:0]           cycles_per_usec_reg;
    dutc_item_t                 up_item;
    dutc_item_t                 held_item;
    logic                       held_valid;
    logic                       held_ready;
    logic [TIME_W-1:0]          mono_usec;
    logic [TIME_W-1:0]          utc_usec;
    logic                       utc_valid;
    logic signed [ADJ_W-1:0]    last_adjustment_usec;
    logic signed [CORR_W-1:0]   rate_correction_x16;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycles_per_usec_reg <= CYCLES_PER_USEC_RST;
        end else if (cfg_wr_en) begin
            cycles_per_usec_reg <= cfg_wr_data;
        end
    end

    assign up_item = {action_t'(s_tuser[0]), s_tdata[ADJ_W-1:0]};

    dutc_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_item  (up_item),
        .dn_valid (held_valid),
        .dn_ready (held_ready),
        .dn_item  (held_item)
    );

    dutc_update #(
        .USEC_PER_PERIOD (USEC_PER_PERIOD),
        .MAX_CORR_X16    (MAX_CORR_X16)
    ) u_update (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cycles_per_usec      (cycles_per_usec_reg),
        .in_valid             (held_valid),
        .in_ready             (held_ready),
        .in_item              (held_item),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .mono_usec            (mono_usec),
        .utc_usec             (utc_usec),
        .utc_valid            (utc_valid),
        .last_adjustment_usec (last_adjustment_usec),
        .rate_correction_x16  (rate_correction_x16)
    );

    // Pack the result item
    assign m_tdata = {3'b000, rate_correction_x16, last_adjustment_usec,
                      utc_valid, utc_usec, mono_usec};

endmodule

`default_nettype wire
